@@ rtl/vgdf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgdf_pkg
// Types and constants shared by the voxel grid dedup filter.
// ----------------------------------------------------------------------------
package vgdf_pkg;

	localparam int SLOT_BITS = 12;
	localparam int TABLE_SLOTS = 1 << SLOT_BITS;
	localparam int INDEX_BITS = 16;
	localparam int EPOCH_BITS = 8;
	localparam logic [31:0] HASH_MULT = 32'd2654435761;
	localparam logic [31:0] RESOLUTION_RESET = 32'd65536;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic               first_of_cloud;
	} point_t;

	typedef struct packed {
		logic        keep;
		logic [31:0] voxel_key;
		logic        table_full;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [32:0] mag;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [32:0] quotient;
	} div_rsp_t;

endpackage

@@ rtl/vgdf_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgdf_divider
// Radix-2 restoring divider: rounded quotient of (2*mag + d) / (2*d),
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vgdf_divider
	import vgdf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [33:0] num_q;
	logic [33:0] den_q;
	logic [34:0] rem_q;
	logic [33:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] rem_sh;
	logic [34:0] rem_sub;

	assign rem_sh  = {rem_q[33:0], num_q[33]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd34;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {req.mag, 1'b0} + {2'b0, req.divisor};
			den_q <= {1'b0, req.divisor, 1'b0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[32:0], 1'b0};
			if (!rem_sub[34]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[32:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[32:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q[32:0];

endmodule

@@ rtl/voxel_grid_dedup_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_grid_dedup_filter
// Voxel index, key hashing and linear-probe dedup of 2-D points.
// ----------------------------------------------------------------------------
// One point at a time: two serial divisions (x then y), a multiply for the
// hash, then table probes (read, then compare) through the single read port
// of the key memory; a long probe run adds a read and a compare per slot
// visited. A first-of-cloud point clears the table by bumping an 8-bit
// epoch; once after reset, and when a first-of-cloud point would wrap the
// epoch, a clearing pass over all 4096 slots runs first (in the wrap case
// before that point is processed).
module voxel_grid_dedup_filter
	import vgdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  point_t      in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output result_t     out_data
);

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_DIVX  = 9'b000000100,
		ST_DIVY  = 9'b000001000,
		ST_HASH  = 9'b000010000,
		ST_READ  = 9'b000100000,
		ST_CMP   = 9'b001000000,
		ST_OUT   = 9'b010000000,
		ST_WAIT  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [31:0] res_q;
	point_t pt_q;
	logic [INDEX_BITS-1:0] xi_q;
	logic [INDEX_BITS-1:0] yi_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic [SLOT_BITS:0] n_q;
	logic [SLOT_BITS:0] clr_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic [31:0] hash_q;
	logic out_valid_q;
	result_t out_q;
	result_t hold_q;
	logic pend_q;

	logic [31:0] key_mem [TABLE_SLOTS];
	logic [EPOCH_BITS-1:0] tag_mem [TABLE_SLOTS];
	logic [31:0] rd_key_q;
	logic [EPOCH_BITS-1:0] rd_tag_q;

	div_req_t dreq;
	div_rsp_t drsp;
	logic [31:0] div_d;
	logic [31:0] cur_coord;
	logic cur_neg;
	logic [32:0] cur_mag;
	logic [INDEX_BITS-1:0] idx;
	logic [31:0] key;
	logic mem_we;
	logic [SLOT_BITS-1:0] mem_wa;
	logic [EPOCH_BITS-1:0] mem_wtag;
	logic slot_live;
	logic clr_last;
	logic wrap_clear;

	vgdf_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign div_d     = (res_q == 32'd0) ? 32'd1 : res_q;
	assign cur_coord = (state_q == ST_IDLE) ? in_data.point_x
		: (state_q == ST_CLEAR) ? pt_q.point_x : pt_q.point_y;
	assign cur_neg   = cur_coord[31];
	assign cur_mag   = cur_neg ? (33'h100000000 - {1'b0, cur_coord}) : {1'b0, cur_coord};
	assign idx       = pt_q.point_x[31] == 1'b1 && state_q == ST_DIVX
		? INDEX_BITS'(16'd0 - drsp.quotient[15:0]) : drsp.quotient[15:0];
	assign key       = {xi_q, yi_q};
	assign slot_live = (rd_tag_q == epoch_q);
	assign clr_last  = (clr_q == (SLOT_BITS+1)'(TABLE_SLOTS - 1));
	// a new cloud at the top epoch needs a full clearing pass first
	assign wrap_clear = in_data.first_of_cloud && (epoch_q == '1);

	assign cfg_ready = (state_q == ST_IDLE && !in_valid) || (state_q == ST_CLEAR && !pend_q);
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		dreq.start   = 1'b0;
		dreq.mag     = cur_mag;
		dreq.divisor = div_d;
		if (state_q == ST_IDLE && in_valid && !wrap_clear) dreq.start = 1'b1;
		if (state_q == ST_CLEAR && pend_q && clr_last) dreq.start = 1'b1;
		if (state_q == ST_DIVX && drsp.done) dreq.start = 1'b1;
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = slot_q;
		mem_wtag = epoch_q;
		if (state_q == ST_CLEAR) begin
			// epoch zero is never live, so cleared tags read as empty
			mem_we   = 1'b1;
			mem_wa   = clr_q[SLOT_BITS-1:0];
			mem_wtag = '0;
		end else if (state_q == ST_CMP && !slot_live) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_wa] <= key;
			tag_mem[mem_wa] <= mem_wtag;
		end
		rd_key_q <= key_mem[slot_q];
		rd_tag_q <= tag_mem[slot_q];
	end

	// y coordinate sign comes from the held point
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) pt_q <= in_data;
		if (state_q == ST_DIVX && drsp.done) xi_q <= idx;
		if (state_q == ST_DIVY && drsp.done)
			yi_q <= pt_q.point_y[31] ? INDEX_BITS'(16'd0 - drsp.quotient[15:0])
				: drsp.quotient[15:0];
		if (state_q == ST_HASH) hash_q <= key * HASH_MULT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			res_q       <= RESOLUTION_RESET;
			clr_q       <= '0;
			epoch_q     <= '0;
			slot_q      <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			hold_q      <= '0;
			pend_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) res_q <= cfg_data;
			if (state_q == ST_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_last) begin
						clr_q   <= '0;
						epoch_q <= EPOCH_BITS'(1);
						pend_q  <= 1'b0;
						state_q <= pend_q ? ST_DIVX : ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (wrap_clear) begin
							pend_q  <= 1'b1;
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_DIVX;
							if (in_data.first_of_cloud)
								epoch_q <= epoch_q + EPOCH_BITS'(1);
						end
					end
				end
				ST_DIVX: if (drsp.done) state_q <= ST_DIVY;
				ST_DIVY: if (drsp.done) state_q <= ST_HASH;
				ST_HASH: begin
					state_q <= ST_WAIT;
					n_q     <= '0;
				end
				ST_WAIT: begin
					slot_q  <= hash_q[SLOT_BITS-1:0];
					state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_CMP;
				ST_CMP: begin
					if (!slot_live || rd_key_q == key) begin
						hold_q.keep       <= !slot_live;
						hold_q.voxel_key  <= key;
						hold_q.table_full <= 1'b0;
						state_q           <= ST_OUT;
					end else if (n_q == (SLOT_BITS+1)'(TABLE_SLOTS - 1)) begin
						hold_q.keep       <= 1'b1;
						hold_q.voxel_key  <= key;
						hold_q.table_full <= 1'b1;
						state_q           <= ST_OUT;
					end else begin
						n_q     <= n_q + 1'b1;
						slot_q  <= slot_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_q   <= hold_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/vgdf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgdf_checker
// Port-level checks on the voxel grid dedup filter.
// ----------------------------------------------------------------------------
module vgdf_checker
	import vgdf_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_stall,
	input logic    out_valid,
	input logic    out_stall,
	input result_t out_data
);

	// a result that is held keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// one point in flight: after a transfer the input stalls
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second point taken while busy");

	// a dropped point never reports a full table
	a_full_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.table_full |-> out_data.keep)
		else $error("table_full without keep");

endmodule

bind voxel_grid_dedup_filter vgdf_checker u_vgdf_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

@@ verif/voxel_grid_dedup_filter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_grid_dedup_filter_tb
// Self-checking bench for the voxel grid dedup filter: a table of directed
// points, a table-fill run up to and past capacity, then random clouds under
// several voxel sizes, scored against listed results or an in-bench key-set model.
// ----------------------------------------------------------------------------
module voxel_grid_dedup_filter_tb;
	import vgdf_pkg::*;

	localparam longint CYCLE_LIMIT = 64'd20_000_000;

	typedef struct {
		point_t  pt;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic    clk;
	logic    arst_n;
	logic    cfg_valid;
	logic    cfg_ready;
	logic    [31:0] cfg_data;
	logic    in_valid;
	logic    in_stall;
	point_t  in_data;
	logic    out_valid;
	logic    out_stall;
	result_t out_data;

	// model of the seen-key set
	logic [31:0] voxel_size;
	logic [31:0] seen_keys [TABLE_SLOTS];
	bit          seen_used [TABLE_SLOTS];

	result_t     pending_results [$];
	dir_row_t    dir_rows [$];
	int          error_count = 0;
	longint      cycle_count = 0;
	int          tx_idle;
	int          rx_idle;

	voxel_grid_dedup_filter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic logic [15:0] cell_of(logic [31:0] raw, logic [31:0] res);
		longint unsigned mag;
		longint unsigned d;
		longint unsigned q;
		logic [63:0]     idx;
		mag = raw[31] ? (64'h1_0000_0000 - raw) : raw;
		d = (res == 0) ? 1 : res;
		q = (2 * mag + d) / (2 * d);
		idx = raw[31] ? (64'd0 - q) : q;
		return idx[15:0];
	endfunction

	function automatic result_t dedup_point(point_t p);
		result_t     r;
		logic [31:0] hash;
		int          slot;
		int          n;
		if (p.first_of_cloud)
			foreach (seen_used[i])
				seen_used[i] = 1'b0;
		r.voxel_key = {cell_of(p.point_x, voxel_size), cell_of(p.point_y, voxel_size)};
		r.keep = 1'b1;
		r.table_full = 1'b0;
		hash = r.voxel_key * HASH_MULT;
		slot = int'(hash[SLOT_BITS-1:0]);
		for (n = 0; n < TABLE_SLOTS; n++) begin
			if (!seen_used[slot]) begin
				seen_used[slot] = 1'b1;
				seen_keys[slot] = r.voxel_key;
				break;
			end
			if (seen_keys[slot] == r.voxel_key) begin
				r.keep = 1'b0;
				break;
			end
			slot = (slot + 1) % TABLE_SLOTS;
		end
		if (n == TABLE_SLOTS)
			r.table_full = 1'b1;
		return r;
	endfunction

	function automatic void add_row(dir_row_t t);
		dir_rows = {dir_rows, t};
	endfunction

	task automatic send_point(point_t p, bit typed, result_t want);
		result_t r;
		if (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = dedup_point(p);
		pending_results = {pending_results, (typed ? want : r)};
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_resolution(logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		voxel_size = v;
	endtask

	function automatic logic [31:0] near_coord(logic [31:0] res);
		longint d;
		longint v;
		d = (res == 0) ? 1 : res;
		v = (longint'($urandom_range(0, 16)) - 8) * d;
		if ($urandom_range(9) < 2)
			v = v + d / 2;
		else
			v = v + longint'($urandom) % (d + 1) - d / 2;
		return v[31:0];
	endfunction

	function automatic dir_row_t row(logic [31:0] x, logic [31:0] y, logic foc, bit typed,
			logic keep, logic [31:0] key);
		dir_row_t t;
		t.pt.point_x = x;
		t.pt.point_y = y;
		t.pt.first_of_cloud = foc;
		t.typed = typed;
		t.want.keep = keep;
		t.want.voxel_key = key;
		t.want.table_full = 1'b0;
		return t;
	endfunction

	// output side: random stall, score every transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", out_data.voxel_key, 32'd0);
				end else begin
					result_t want;
					want = pending_results.pop_front();
					if (out_data.keep !== want.keep)
						report_mismatch("keep", {31'b0, out_data.keep}, {31'b0, want.keep});
					if (out_data.voxel_key !== want.voxel_key)
						report_mismatch("voxel_key", out_data.voxel_key, want.voxel_key);
					if (out_data.table_full !== want.table_full)
						report_mismatch("table_full", {31'b0, out_data.table_full},
							{31'b0, want.table_full});
				end
			end
			out_stall <= (rx_idle != 0 && $urandom_range(99) < rx_idle);
		end
	end

	initial begin
		logic [31:0] sizes [7];
		point_t      p;
		result_t     none;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		tx_idle = 20;
		rx_idle = 63;
		none = '0;
		voxel_size = RESOLUTION_RESET;
		foreach (seen_used[i]) begin
			seen_used[i] = 1'b0;
			seen_keys[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed points at the reset voxel size of 1.0
		add_row(row(32'h0, 32'h0, 1'b1, 1'b1, 1'b1, 32'h0000_0000));
		add_row(row(32'h0, 32'h0, 1'b0, 1'b1, 1'b0, 32'h0000_0000));
		add_row(row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 1'b1, 32'h8000_8000));
		add_row(row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h8000_8000));
		add_row(row(32'h0000_8000, 32'hFFFF_8000, 1'b0, 1'b1, 1'b1, 32'h0001_FFFF));
		add_row(row(32'h0000_7FFF, 32'hFFFF_8001, 1'b0, 1'b1, 1'b0, 32'h0000_0000));
		add_row(row(32'h0001_8000, 32'hFFFE_8000, 1'b0, 1'b1, 1'b1, 32'h0002_FFFE));
		add_row(row(32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0));
		add_row(row(32'hFFFF_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0));
		add_row(row(32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0));
		add_row(row(32'h0, 32'h0, 1'b1, 1'b1, 1'b1, 32'h0000_0000));
		add_row(row(32'h0002_8000, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0));
		add_row(row(32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b0, 1'b0, 32'h0));
		add_row(row(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 32'h0));
		foreach (dir_rows[i])
			send_point(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].want);
		drain();

		// fill every slot, then push new keys into the full table
		tx_idle = 0;
		rx_idle = 0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			p.point_x = (i >> 6) << 16;
			p.point_y = (i & 63) << 16;
			p.first_of_cloud = (i == 0);
			send_point(p, 1'b0, none);
		end
		for (int i = 0; i < 3; i++) begin
			p.point_x = (100 + i) << 16;
			p.point_y = 32'h0;
			p.first_of_cloud = 1'b0;
			send_point(p, 1'b0, none);
		end
		p.point_x = 32'h0;
		p.point_y = 32'h0;
		send_point(p, 1'b0, none);
		p.first_of_cloud = 1'b1;
		send_point(p, 1'b0, none);
		drain();

		sizes[0] = 32'd0;
		sizes[1] = 32'd1;
		sizes[2] = 32'hFFFF_FFFF;
		sizes[3] = 32'd3;
		sizes[4] = 32'h0010_0000;
		sizes[5] = $urandom;
		sizes[6] = RESOLUTION_RESET;
		for (int ph = 0; ph < 7; ph++) begin
			tx_idle = (ph < 3) ? 20 : (ph < 5) ? 63 : 0;
			rx_idle = (ph < 3) ? 63 : (ph < 5) ? 20 : 0;
			write_resolution(sizes[ph]);
			for (int i = 0; i < 215; i++) begin
				if ($urandom_range(9) < 7) begin
					p.point_x = near_coord(voxel_size);
					p.point_y = near_coord(voxel_size);
				end else begin
					p.point_x = $urandom;
					p.point_y = $urandom;
				end
				p.first_of_cloud = ($urandom_range(99) < 4);
				send_point(p, 1'b0, none);
			end
			drain();
		end

		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
